[src/grpa_pkg.sv]
`default_nettype none

package grpa_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CAR_COUNT = 2'd0;
    localparam logic [1:0] CFG_SHORTFALL = 2'd1;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 14;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CAR_CNT_W   = 5;
    localparam int unsigned LIMIT_W     = 14;
    localparam int unsigned PROD_W      = COUNT_W + LIMIT_W;
    localparam int unsigned S_DATA_W    = 2 * TIME_W;
    localparam int unsigned M_DATA_W    = 24;

    // shares are in hundredths of a percent
    localparam logic [LIMIT_W-1:0] SHARE_SCALE = 14'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_VERDICT,
        ST_RESULT
    } grpa_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic verdict;
        logic emit;
    } grpa_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } grpa_stat_t;

endpackage

`default_nettype wire

[src/greedy_resource_pool_admission.sv]
`default_nettype none

// Greedy admission into a pool of up to CAR_SLOTS resources. Each input beat
// is a request (start, end); the resource that frees earliest (lowest slot on
// a tie) takes it if it is free by the start time, and then stays busy until
// the end time. Every request gives one result beat: accepted flag and the
// running accepted count of the batch. The beat with tlast closes the batch:
// its result carries tlast and the verdict need_more_resources, set when
// 10000*rejected > shortfall_limit*requests; the pool and counters then clear.
// Counters saturate at min(65535, REQUEST_CAP). Each item scans n slots,
// n being car_count held to 1..CAR_SLOTS: the free times live in a
// single-port read RAM scanned one slot a cycle, followed by compare,
// update, verdict and result steps. One request is in
// work at a time; the next is taken as soon as the result sits in the output
// register. Configuration writes are always taken (cfg_ready is tied high)
// and belong between batches or while idle.

module greedy_resource_pool_admission
    import grpa_pkg::*;
#(
    parameter int unsigned CAR_SLOTS   = 16,
    parameter int unsigned REQUEST_CAP = 65535
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // request channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,   // start_time, end_time
    input  wire logic                   s_tlast,   // last_request
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_DATA_W-1:0]    m_tdata,   // accepted, accepted_count,
                                                   // need_more_resources, pad
    output logic                        m_tlast,   // batch_done
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    grpa_cmd_t          cmd;
    grpa_stat_t         stat;
    logic [CAR_CNT_W-1:0] car_count_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_accepted;
    logic [COUNT_W-1:0] out_count;
    logic               out_need_more;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_count_reg <= CAR_CNT_W'(1);
            limit_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CAR_COUNT: car_count_reg <= cfg_data[CAR_CNT_W-1:0];
                CFG_SHORTFALL: limit_reg     <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    grpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    grpa_dp #(
        .CAR_SLOTS   (CAR_SLOTS),
        .REQUEST_CAP (REQUEST_CAP)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .car_count       (car_count_reg),
        .shortfall_limit (limit_reg),
        .start_time      (s_tdata[TIME_W-1:0]),
        .end_time        (s_tdata[2*TIME_W-1:TIME_W]),
        .last_request    (s_tlast),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_accepted    (out_accepted),
        .out_count       (out_count),
        .out_need_more   (out_need_more),
        .out_last        (m_tlast)
    );

    // pack result fields, lowest first, zero pad to whole bytes
    assign m_tdata = {6'd0, out_need_more, out_count, out_accepted};

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    // verdict only on the closing beat of a batch
    a_verdict_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tdata[17])
        else $error("verdict raised outside batch end");

    // an accepted request is counted
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[16:1] != '0)
        else $error("accepted beat with zero count");

endmodule

`default_nettype wire

[src/grpa_ram.sv]
`default_nettype none

module grpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/grpa_ctrl.sv]
`default_nettype none

module grpa_ctrl
    import grpa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire grpa_stat_t stat,
    output grpa_cmd_t       cmd
);

    grpa_state_t state_reg;
    grpa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read still being compared
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_VERDICT;
            end
            ST_VERDICT: begin
                cmd.verdict = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/grpa_dp.sv]
`default_nettype none

module grpa_dp
    import grpa_pkg::*;
#(
    parameter int unsigned CAR_SLOTS   = 16,
    parameter int unsigned REQUEST_CAP = 65535
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire grpa_cmd_t            cmd,
    output grpa_stat_t                stat,
    input  wire logic [CAR_CNT_W-1:0] car_count,
    input  wire logic [LIMIT_W-1:0]   shortfall_limit,
    input  wire logic [TIME_W-1:0]    start_time,
    input  wire logic [TIME_W-1:0]    end_time,
    input  wire logic                 last_request,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic                      out_accepted,
    output logic [COUNT_W-1:0]        out_count,
    output logic                      out_need_more,
    output logic                      out_last
);

    localparam int unsigned SLOT_W = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;
    localparam logic [COUNT_W-1:0] CNT_CAP =
        (REQUEST_CAP > 65535) ? 16'hFFFF : COUNT_W'(REQUEST_CAP);

    // request held for the whole item
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  end_reg;
    logic               last_reg;

    // scan of the pool
    logic [SLOT_W-1:0]  rd_idx_reg;
    logic               pend_valid_reg;
    logic [SLOT_W-1:0]  pend_idx_reg;
    logic [TIME_W-1:0]  best_time_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [CAR_SLOTS-1:0] valid_reg;
    logic [TIME_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]  cur_time;
    logic [SLOT_W-1:0]  active_last;

    // batch counters and verdict
    logic [COUNT_W-1:0] acc_total_reg;
    logic [COUNT_W-1:0] req_total_reg;
    logic               ok_reg;
    logic [PROD_W-1:0]  prod_rej_reg;
    logic [PROD_W-1:0]  prod_lim_reg;
    logic [COUNT_W-1:0] rejected;
    logic               ok;

    // output register
    logic               m_valid_reg;
    logic               acc_out_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               need_out_reg;
    logic               last_out_reg;

    // zero means one, above the pool size means the whole pool
    always_comb begin
        if (car_count == '0) begin
            active_last = '0;
        end else if (int'(car_count) > int'(CAR_SLOTS)) begin
            active_last = SLOT_W'(CAR_SLOTS - 1);
        end else begin
            active_last = SLOT_W'(car_count - CAR_CNT_W'(1));
        end
    end

    grpa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CAR_SLOTS)
    ) u_free_time (
        .aclk  (aclk),
        .we    (cmd.update && ok),
        .waddr (best_idx_reg),
        .wdata (end_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // a slot not written since the batch began reads as zero
    assign cur_time = valid_reg[pend_idx_reg] ? ram_rdata : '0;
    assign ok       = best_time_reg <= start_reg;
    assign rejected = (req_total_reg >= acc_total_reg) ? req_total_reg - acc_total_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg <= start_time;
            end_reg   <= end_time;
            last_reg  <= last_request;
        end
        if (pend_valid_reg) begin
            if (pend_idx_reg == '0 || cur_time < best_time_reg) begin
                best_time_reg <= cur_time;
                best_idx_reg  <= pend_idx_reg;
            end
        end
        pend_idx_reg <= rd_idx_reg;
        if (cmd.update) begin
            ok_reg <= ok;
        end
        if (cmd.verdict) begin
            prod_rej_reg <= PROD_W'(rejected) * PROD_W'(SHARE_SCALE);
            prod_lim_reg <= PROD_W'(shortfall_limit) * PROD_W'(req_total_reg);
        end
        if (cmd.emit) begin
            acc_out_reg   <= ok_reg;
            count_out_reg <= acc_total_reg;
            need_out_reg  <= last_reg && (prod_rej_reg > prod_lim_reg);
            last_out_reg  <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
            acc_total_reg  <= '0;
            req_total_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= cmd.scan;
            if (cmd.load) begin
                rd_idx_reg <= '0;
            end else if (cmd.scan) begin
                rd_idx_reg <= rd_idx_reg + SLOT_W'(1);
            end
            if (cmd.update) begin
                if (ok) begin
                    valid_reg[best_idx_reg] <= 1'b1;
                    if (acc_total_reg < CNT_CAP) begin
                        acc_total_reg <= acc_total_reg + COUNT_W'(1);
                    end
                end
                if (req_total_reg < CNT_CAP) begin
                    req_total_reg <= req_total_reg + COUNT_W'(1);
                end
            end
            // batch end: pool and counters back to reset
            if (cmd.emit && last_reg) begin
                valid_reg     <= '0;
                acc_total_reg <= '0;
                req_total_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_last = rd_idx_reg == active_last;
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid      = m_valid_reg;
    assign out_accepted  = acc_out_reg;
    assign out_count     = count_out_reg;
    assign out_need_more = need_out_reg;
    assign out_last      = last_out_reg;

    a_acc_le_req: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_total_reg <= req_total_reg)
        else $error("accepted total exceeds request total");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> rd_idx_reg <= active_last)
        else $error("scan ran past the active slots");

endmodule

`default_nettype wire

[test/greedy_resource_pool_admission_tb.sv]
`default_nettype none

module greedy_resource_pool_admission_tb;
    import grpa_pkg::*;

    localparam int unsigned POOL_SLOTS   = 16;
    localparam int unsigned REQ_CEILING  = 65535;
    localparam int unsigned COUNT_CAP    = (REQ_CEILING < 65535) ? REQ_CEILING : 65535;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned STALL_LIMIT  = 4000;   // cycles with no beat at all
    localparam int unsigned SETTLE_WAIT  = 40;
    localparam int unsigned PRINT_CAP    = 40;

    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;

    // result beat layout, lowest bit up
    localparam int unsigned M_ACC_BIT   = 0;
    localparam int unsigned M_COUNT_LSB = 1;
    localparam int unsigned M_NEED_BIT  = 17;

    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] count;
        logic               need;
        logic               done;
    } admission_t;

    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_CARS,
        ROW_LIMIT,
        ROW_SPARE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [13:0]        cfg_value;
        logic [31:0]        t_start;
        logic [31:0]        t_end;
        logic               lst;
        logic               typed;
        logic               x_acc;
        logic [COUNT_W-1:0] x_count;
        logic               x_need;
    } dir_row_t;

    // Directed rows. Typed expectations only where they are obvious; the rest
    // go through the predictor.
    //   kind       cfg     start          end            last typed acc count need
    localparam int unsigned DIR_ROWS = 34;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // straight after reset: one resource, zero limit
        '{ROW_REQ,   14'd0,  32'd0,         32'd100,       1'b0, 1'b1, 1'b1, 16'd1, 1'b0},
        '{ROW_REQ,   14'd0,  32'd50,        32'd60,        1'b0, 1'b1, 1'b0, 16'd1, 1'b0},
        '{ROW_REQ,   14'd0,  32'd100,       32'hFFFFFFFF,  1'b1, 1'b1, 1'b1, 16'd2, 1'b1},
        // fresh pool after batch end, extreme times
        '{ROW_REQ,   14'd0,  32'hFFFFFFFF,  32'd0,         1'b1, 1'b1, 1'b1, 16'd1, 1'b0},
        // zero resources behaves as one
        '{ROW_CARS,  14'd0,  32'd0,         32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'hFFFFFFFF,  1'b0, 1'b1, 1'b1, 16'd1, 1'b0},
        '{ROW_REQ,   14'd0,  32'hFFFFFFFE,  32'd5,         1'b1, 1'b1, 1'b0, 16'd1, 1'b1},
        // three slots, ties to lowest slot, mid limit
        '{ROW_CARS,  14'd3,  32'd0,         32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_LIMIT, 14'd5000, 32'd0,       32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd10,        32'd20,        1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd5,         32'd30,        1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd40,        1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd15,        32'd50,        1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd25,        32'd50,        1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd1000,      32'd2000,      1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
        // pool shrunk and regrown mid-batch: parked slots keep their times
        '{ROW_REQ,   14'd0,  32'd0,         32'd1000,      1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd900,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_CARS,  14'd1,  32'd0,         32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd500,       32'd600,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        // too many resources clamps to the full pool
        '{ROW_CARS,  14'd31, 32'd0,         32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd950,       32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_CARS,  14'd2,  32'd0,         32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd900,       32'd1,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_LIMIT, 14'd10000, 32'd0,      32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd0,         1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
        // limit above 10000: verdict can never be raised
        '{ROW_LIMIT, 14'h3FFF, 32'd0,       32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd5,         32'd5,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd5,         32'd5,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd4,         32'd4,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd0,         1'b1, 1'b1, 1'b0, 16'd2, 1'b0},
        // write to an unused index leaves both registers alone
        '{ROW_SPARE, 14'h3FFF, 32'd0,       32'd0,         1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd7,         1'b0, 1'b1, 1'b1, 16'd1, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd7,         1'b0, 1'b1, 1'b1, 16'd2, 1'b0},
        '{ROW_REQ,   14'd0,  32'd0,         32'd7,         1'b1, 1'b1, 1'b0, 16'd2, 1'b0}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [TIME_W-1:0]    pool_free [POOL_SLOTS];
    int unsigned          batch_accepts;
    int unsigned          batch_requests;
    logic [CAR_CNT_W-1:0] cfg_cars;
    logic [LIMIT_W-1:0]   cfg_limit;

    // newest at the front, oldest at the back
    admission_t pending_results [$];

    int unsigned errors;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned batches_closed;
    int unsigned cfg_writes;
    int unsigned stall_cycles;
    bit          no_idle;

    greedy_resource_pool_admission #(
        .CAR_SLOTS   (POOL_SLOTS),
        .REQUEST_CAP (REQ_CEILING)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // --- predictor ---------------------------------------------------------

    function automatic void clear_pool();
        for (int i = 0; i < POOL_SLOTS; i++) pool_free[i] = '0;
        batch_accepts  = 0;
        batch_requests = 0;
    endfunction

    // Earliest-free active slot takes the request if it is free by the start.
    function automatic admission_t admit_request(logic [TIME_W-1:0] t_start,
                                                 logic [TIME_W-1:0] t_end,
                                                 logic lst);
        int unsigned     active;
        int unsigned     best;
        admission_t      r;
        longint unsigned rejects;
        active = (cfg_cars == 0) ? 1 : ((cfg_cars > POOL_SLOTS) ? POOL_SLOTS : cfg_cars);
        best   = 0;
        for (int unsigned i = 1; i < active; i++) begin
            if (pool_free[i] < pool_free[best]) best = i;
        end
        r.accepted = (pool_free[best] <= t_start);
        if (r.accepted) begin
            pool_free[best] = t_end;
            if (batch_accepts < COUNT_CAP) batch_accepts++;
        end
        if (batch_requests < COUNT_CAP) batch_requests++;
        r.count = batch_accepts[COUNT_W-1:0];
        r.need  = 1'b0;
        r.done  = lst;
        if (lst) begin
            // verdict is taken on the saturated counters
            rejects = (batch_requests >= batch_accepts) ? batch_requests - batch_accepts : 0;
            r.need  = (longint'(SHARE_SCALE) * rejects >
                       longint'(cfg_limit) * longint'(batch_requests));
            clear_pool();
        end
        return r;
    endfunction

    // --- checking ----------------------------------------------------------

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task automatic check_result();
        admission_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
            return;
        end
        want = pending_results.pop_back();
        if (m_tdata[M_ACC_BIT] !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b",
                                      m_tdata[M_ACC_BIT], want.accepted));
        if (m_tdata[M_COUNT_LSB +: COUNT_W] !== want.count)
            report_mismatch($sformatf("accepted_count %0d, expected %0d",
                                      m_tdata[M_COUNT_LSB +: COUNT_W], want.count));
        if (m_tdata[M_NEED_BIT] !== want.need)
            report_mismatch($sformatf("need_more_resources %b, expected %b",
                                      m_tdata[M_NEED_BIT], want.need));
        if (m_tlast !== want.done)
            report_mismatch($sformatf("batch_done %b, expected %b", m_tlast, want.done));
        results_seen++;
    endtask

    // --- driving -----------------------------------------------------------

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // One request beat. Valid stays high on return so a zero gap next time
    // gives back-to-back beats.
    task automatic send_req(input logic [TIME_W-1:0] t_start, input logic [TIME_W-1:0] t_end,
                            input logic lst, input logic use_typed, input admission_t typed_exp);
        int unsigned gap;
        admission_t  predicted;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t_end, t_start};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = admit_request(t_start, t_end, lst);
        pending_results.push_front(use_typed ? typed_exp : predicted);
        requests_sent++;
        if (lst) batches_closed++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // sender held off until the pool has returned every result
    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        stop_sending();
        wait_drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_CAR_COUNT: cfg_cars  = value[CAR_CNT_W-1:0];
            CFG_SHORTFALL: cfg_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // --- result side: random back-pressure ---------------------------------

    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap();
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_result();
        end
    end

    // --- watchdog: any beat on any channel counts as progress -------------

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_results.size());
            $display("greedy_resource_pool_admission regression: fail");
            $finish;
        end
    end

    // --- main sequence -----------------------------------------------------

    initial begin
        dir_row_t          row;
        admission_t        typed_exp;
        int unsigned       random_sent;
        int unsigned       len;
        int unsigned       cars;
        logic [TIME_W-1:0] clk_now;
        logic [TIME_W-1:0] t_s;
        logic [TIME_W-1:0] t_e;
        logic [LIMIT_W-1:0] lim;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_CAR_COUNT;
        cfg_data       = '0;
        errors         = 0;
        requests_sent  = 0;
        results_seen   = 0;
        batches_closed = 0;
        cfg_writes     = 0;
        no_idle        = 1'b0;
        cfg_cars       = 5'd1;
        cfg_limit      = '0;
        clear_pool();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_REQ: begin
                    typed_exp = '{row.x_acc, row.x_count, row.x_need, row.lst};
                    send_req(row.t_start, row.t_end, row.lst, row.typed, typed_exp);
                end
                ROW_CARS:  write_register(CFG_CAR_COUNT, row.cfg_value);
                ROW_LIMIT: write_register(CFG_SHORTFALL, row.cfg_value);
                default:   write_register(CFG_SPARE, row.cfg_value);
            endcase
        end

        // random batches: mostly time-ordered traffic so slots fill and free
        // up, with some raw noise mixed in
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       cars = 0;
                    1:       cars = $urandom_range(17, 31);
                    2:       cars = POOL_SLOTS;
                    default: cars = $urandom_range(1, POOL_SLOTS);
                endcase
                // upper bits are don't-care for the car count
                write_register(CFG_CAR_COUNT, {9'($urandom), 5'(cars)});
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       lim = '0;
                    1:       lim = 14'd10000;
                    2:       lim = 14'h3FFF;
                    3:       lim = 14'($urandom);
                    default: lim = 14'($urandom_range(0, 10000));
                endcase
                write_register(CFG_SHORTFALL, lim);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            len     = $urandom_range(1, 40);
            clk_now = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
            for (int unsigned k = 0; k < len; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    t_s = $urandom;
                    t_e = $urandom;
                end else begin
                    t_s     = clk_now + $urandom_range(0, 40);
                    clk_now = t_s;
                    t_e     = t_s + $urandom_range(0, 300);
                end
                send_req(t_s, t_e, (k == len - 1), 1'b0, '0);
                random_sent++;
                // occasional hold-off until the block has answered everything
                if ($urandom_range(0, 19) == 0) begin
                    stop_sending();
                    wait_drain();
                end
            end
        end
        no_idle = 1'b0;

        stop_sending();
        wait_drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("run covered %0d requests in %0d batches with %0d register writes,",
                 requests_sent, batches_closed, cfg_writes);
        $display("random stalls on both sides and pool sizes from zero to over full; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("greedy_resource_pool_admission regression: pass");
        end else begin
            $display("greedy_resource_pool_admission regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[greedy_resource_pool_admission.f]
src/grpa_pkg.sv
src/grpa_ram.sv
src/grpa_ctrl.sv
src/grpa_dp.sv
src/greedy_resource_pool_admission.sv
test/greedy_resource_pool_admission_tb.sv
